// File: design/mbrd_pkg.sv
// Shared constants for the Modbus RTU response deframer: status codes,
// function codes, frame lengths and CRC-16 parameters. No dependencies.
`default_nettype none

package mbrd_pkg;

  localparam int BUFFER_CAPACITY_DEF = 256;

  localparam int STATUS_W = 3;
  localparam int POS_W    = 8;
  localparam int FLEN_W   = 9;
  localparam int CRC_W    = 16;
  localparam int BYTE_W   = 8;

  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEED_MORE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_READY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd6;

  localparam int FC_EXCEPTION_BIT = 7;
  localparam logic [BYTE_W-1:0] FC_READ_FIRST  = 8'h01;
  localparam logic [BYTE_W-1:0] FC_READ_LAST   = 8'h04;
  localparam logic [BYTE_W-1:0] FC_WRITE_COIL  = 8'h05;
  localparam logic [BYTE_W-1:0] FC_WRITE_REG   = 8'h06;
  localparam logic [BYTE_W-1:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [BYTE_W-1:0] FC_WRITE_REGS  = 8'h10;

  localparam int EXC_LEN      = 5;
  localparam int READ_HDR_LEN = 5;
  localparam int WRITE_LEN    = 8;
  localparam int HDR_BYTES    = 3;
  localparam int CRC_BYTES    = 2;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

endpackage

`default_nettype wire

// File: design/mbrd_crc16.sv
// One-byte update of the reflected Modbus CRC-16.
// Depends on mbrd_pkg for the polynomial and widths.
`default_nettype none

module mbrd_crc16 (
  input  wire logic [mbrd_pkg::CRC_W-1:0]  crc_in,
  input  wire logic [mbrd_pkg::BYTE_W-1:0] data_in,
  output logic      [mbrd_pkg::CRC_W-1:0]  crc_out
);
  import mbrd_pkg::*;

  logic [CRC_W-1:0] c;

  always_comb begin
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// File: design/modbus_rtu_response_deframer_top.sv
// The result of a transaction is registered and valid the cycle after acceptance.
// Throughput: 1 byte per cycle, set by the combinational CRC byte update and the
// length compare; a stalled result register holds in_tready low.
// Reset (rst_n low, synchronous): no request pending, empty frame, CRC at 0xFFFF,
// result register empty. Depends on mbrd_pkg and mbrd_crc16.
`default_nettype none

module modbus_rtu_response_deframer_top #(
  parameter int BUFFER_CAPACITY = mbrd_pkg::BUFFER_CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [7:0] byte_position, [16:8] frame_length,
                                       // [32:17] computed_crc, [39:33] zero
  output logic      [2:0]  out_tuser   // [2:0] status
);
  import mbrd_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_CAPACITY + 1);
  localparam int CMP_W = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;

  logic                pending_r, pending_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [BYTE_W-1:0]   fc_r, fc_nxt;
  logic [BYTE_W-1:0]   lb_r, lb_nxt;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic [BYTE_W-1:0]   crc_lo_r, crc_lo_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, status;
  logic [POS_W-1:0]    out_pos_r, pos;
  logic [FLEN_W-1:0]   out_flen_r, flen;
  logic [CRC_W-1:0]    out_crc_r, crc_o;

  logic                in_acc;
  logic [CRC_W-1:0]    crc_upd;
  logic [FLEN_W-1:0]   exp_len;
  logic [CMP_W-1:0]    pos_ext, crc_pos;
  logic [BYTE_W-1:0]   byte_in;

  assign byte_in   = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  mbrd_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (byte_in),
    .crc_out (crc_upd)
  );

  always_comb begin
    if (fc_r[FC_EXCEPTION_BIT]) begin
      exp_len = FLEN_W'(EXC_LEN);
    end else if (fc_r >= FC_READ_FIRST && fc_r <= FC_READ_LAST) begin
      exp_len = FLEN_W'(READ_HDR_LEN) + FLEN_W'(lb_r);
    end else if (fc_r == FC_WRITE_COIL || fc_r == FC_WRITE_REG ||
                 fc_r == FC_WRITE_COILS || fc_r == FC_WRITE_REGS) begin
      exp_len = FLEN_W'(WRITE_LEN);
    end else begin
      exp_len = '0;
    end
  end

  assign pos_ext = CMP_W'(count_r);
  assign crc_pos = CMP_W'(exp_len) - CMP_W'(CRC_BYTES);

  always_comb begin
    pending_nxt = pending_r;
    count_nxt   = count_r;
    fc_nxt      = fc_r;
    lb_nxt      = lb_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    status      = ST_IGNORED;
    pos         = '0;
    flen        = '0;
    crc_o       = '0;
    if (in_tuser[0]) begin
      pending_nxt = 1'b1;
      count_nxt   = '0;
      fc_nxt      = '0;
      lb_nxt      = '0;
      crc_nxt     = CRC_INIT;
      crc_lo_nxt  = '0;
      status      = ST_STARTED;
    end else if (!pending_r) begin
      status = ST_IGNORED;
    end else if (count_r >= CNT_W'(BUFFER_CAPACITY)) begin
      pos        = pos_ext[POS_W-1:0];
      count_nxt  = '0;
      fc_nxt     = '0;
      lb_nxt     = '0;
      crc_nxt    = CRC_INIT;
      crc_lo_nxt = '0;
      status     = ST_OVERFLOW;
    end else begin
      pos       = pos_ext[POS_W-1:0];
      count_nxt = count_r + CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        fc_nxt = byte_in;
      end
      if (count_r == CNT_W'(2)) begin
        lb_nxt = byte_in;
      end
      if (count_r < CNT_W'(HDR_BYTES)) begin
        crc_nxt = crc_upd;
        status  = ST_NEED_MORE;
      end else if (exp_len == '0) begin
        count_nxt  = '0;
        fc_nxt     = '0;
        lb_nxt     = '0;
        crc_nxt    = CRC_INIT;
        crc_lo_nxt = '0;
        status     = ST_UNKNOWN;
      end else begin
        flen = exp_len;
        if (pos_ext < crc_pos) begin
          crc_nxt = crc_upd;
          status  = ST_NEED_MORE;
        end else if (pos_ext == crc_pos) begin
          crc_lo_nxt = byte_in;
          status     = ST_NEED_MORE;
        end else begin
          crc_o = crc_r;
          if ({byte_in, crc_lo_r} == crc_r) begin
            status      = ST_READY;
            pending_nxt = 1'b0;
          end else begin
            status = ST_MISMATCH;
          end
          count_nxt  = '0;
          fc_nxt     = '0;
          lb_nxt     = '0;
          crc_nxt    = CRC_INIT;
          crc_lo_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      count_r   <= '0;
      fc_r      <= '0;
      lb_r      <= '0;
      crc_r     <= CRC_INIT;
      crc_lo_r  <= '0;
    end else if (in_acc) begin
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
      fc_r      <= fc_nxt;
      lb_r      <= lb_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r <= status;
      out_pos_r    <= pos;
      out_flen_r   <= flen;
      out_crc_r    <= crc_o;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_crc_r, out_flen_r, out_pos_r};

endmodule

`default_nettype wire

// File: design/mbrd_checker.sv
// Port-level checks for the Modbus RTU response deframer, bound to the top level.
// Depends on mbrd_pkg and modbus_rtu_response_deframer_top.
`default_nettype none

module mbrd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import mbrd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_crc_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_READY && out_tuser != ST_MISMATCH
      |-> out_tdata[32:17] == '0)
    else $error("crc reported on a non-final byte");

  a_flen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_IGNORED || out_tuser == ST_STARTED ||
                   out_tuser == ST_UNKNOWN || out_tuser == ST_OVERFLOW)
      |-> out_tdata[16:8] == '0)
    else $error("frame length reported when not known");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0]
      |=> out_tvalid && out_tuser == ST_STARTED && out_tdata[7:0] == '0)
    else $error("start transaction did not report started");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == '0 && out_tuser <= ST_STARTED)
    else $error("bad padding or status code");

endmodule

bind modbus_rtu_response_deframer_top mbrd_checker u_mbrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
